// ===== src/sobel_pkg.sv =====
package sobel_pkg;

  // Field widths of the pixel and result channels.
  localparam int PIXEL_W = 8;
  localparam int MAG_W   = 8;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 12;

  // Configuration register widths and the write port.
  localparam int WIDTH_REG_W  = 10;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Frame geometry limits and reset sizes.
  localparam int MIN_SIZE     = 3;
  localparam int MAX_HEIGHT   = 4096;
  localparam int WIDTH_RESET  = 512;
  localparam int HEIGHT_RESET = 512;

  // Magnitude clamp and the number of root digits, one per pipeline stage.
  localparam logic [MAG_W-1:0] MAG_LIMIT = 8'd255;
  localparam int SQRT_STEPS = 8;

  // Position and frame marker that travel alongside a result.
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last;
  } meta_t;

endpackage

// ===== src/sobel_ram.sv =====
module sobel_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port and one read port with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sobel_edge_magnitude.sv =====
// Sobel 3x3 edge magnitude over a raster stream of 8-bit grey pixels. The block
// takes one pixel per clock while in_ready is high and, once the pixel at
// column x, row y arrives with x >= 2 and y >= 2, gives floor(sqrt(gx*gx +
// gy*gy)) clamped to 255 for the centre pixel (x-1, y-1); border pixels give
// no result. The two previous rows sit in one line store RAM, one 16-bit word
// per column, which is read at the next column's address while the current
// column is written, so the sustained rate is one pixel per cycle unless the
// output stalls. A result passes one stage for the gradients, one for the
// squares and sum, and eight for the square root, one result bit per stage.
// Every stage moves on as soon as the stage after it has room, so pixels are
// taken while a result waits at the output until the stages fill. The line
// store has no clearing pass and needs no start-up time after reset. The user
// writes frame width and height through the configuration port while the
// block is idle (not enforced); out-of-range sizes clamp to 3..MAX_WIDTH, 3..4096.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sobel_pkg::PIXEL_W-1:0]     pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sobel_pkg::MAG_W-1:0]       magnitude,
  output logic [sobel_pkg::COL_W-1:0]       out_column,
  output logic [sobel_pkg::ROW_W-1:0]       out_row,
  output logic                              frame_last
);
  import sobel_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = CW + 1;
  localparam int WW  = ((CW > WIDTH_REG_W) ? CW : WIDTH_REG_W) + 1;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [WW-1:0]           width_used;
  logic [HEIGHT_REG_W-1:0] height_used;
  logic [CW-1:0]           col_count, col_next, ram_raddr;
  logic [ROW_W-1:0]        row_count, row_next;
  logic                    row_end, frame_end, produced, accept;
  logic [2*PIXEL_W-1:0]    ram_rdata;
  logic [PIXEL_W-1:0]      ls_top, ls_mid;
  logic [PIXEL_W-1:0]      win [0:5];
  logic [9:0]              sum_right, sum_left, sum_bottom, sum_top;
  logic signed [10:0]      gx_next, gy_next, gx, gy;
  logic                    g_vld, g_take;
  meta_t                   g_meta, meta_next;
  logic signed [21:0]      gx_sq, gy_sq;
  logic [21:0]             sum_sq;

  // Square root pipeline; entry 0 holds the sum, entry k holds k result bits.
  logic                    sq_vld  [0:SQRT_STEPS];
  logic                    sq_take [0:SQRT_STEPS];
  logic [15:0]             sq_v    [0:SQRT_STEPS];
  logic                    sq_sat  [0:SQRT_STEPS];
  logic [MAG_W-1:0]        sq_r    [0:SQRT_STEPS];
  logic [15:0]             sq_rsq  [0:SQRT_STEPS];
  meta_t                   sq_meta [0:SQRT_STEPS];
  logic [MAG_W-1:0]        cand_r  [1:SQRT_STEPS];
  logic [16:0]             cand_sq [1:SQRT_STEPS];
  logic                    cand_ok [1:SQRT_STEPS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(WIDTH_RESET);
      image_height <= HEIGHT_REG_W'(HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame size in use, clamped to the supported range.
  always_comb begin
    width_used = WW'(image_width);
    if (width_used < WW'(MIN_SIZE)) begin
      width_used = WW'(MIN_SIZE);
    end else if (width_used > WW'(MAX_WIDTH)) begin
      width_used = WW'(MAX_WIDTH);
    end
    height_used = image_height;
    if (height_used < HEIGHT_REG_W'(MIN_SIZE)) begin
      height_used = HEIGHT_REG_W'(MIN_SIZE);
    end else if (height_used > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      height_used = HEIGHT_REG_W'(MAX_HEIGHT);
    end
  end

  assign accept    = in_valid && in_ready;
  assign row_end   = WW'(col_count) >= (width_used - WW'(1));
  assign frame_end = row_end && (HEIGHT_REG_W'(row_count) >= (height_used - HEIGHT_REG_W'(1)));
  assign produced  = (col_count >= CW'(2)) && (row_count >= ROW_W'(2));

  // Position of the next pixel in the frame.
  always_comb begin
    col_next = col_count + CW'(1);
    row_next = row_count;
    if (frame_end) begin
      col_next = '0;
      row_next = '0;
    end else if (row_end) begin
      col_next = '0;
      row_next = row_count + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // Line store: the upper byte is row y-2, the lower byte row y-1. The read
  // address runs one column ahead, and a row is always at least three pixels
  // long, so a read never meets the write to the same column.
  assign ram_raddr = accept ? col_next : col_count;

  sobel_ram #(
    .WIDTH(2 * PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (col_count),
    .wdata ({ls_mid, pixel}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ls_top = ram_rdata[2*PIXEL_W-1:PIXEL_W];
  assign ls_mid = ram_rdata[PIXEL_W-1:0];

  // Window of the two previous columns: left column in 0..2, centre in 3..5.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (accept) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= ls_top;
      win[4] <= ls_mid;
      win[5] <= pixel;
    end
  end

  // Weighted column and row sums, then the two gradients.
  always_comb begin
    sum_right  = 10'(ls_top) + (10'(ls_mid) << 1) + 10'(pixel);
    sum_left   = 10'(win[0]) + (10'(win[1]) << 1) + 10'(win[2]);
    sum_bottom = 10'(win[2]) + (10'(win[5]) << 1) + 10'(pixel);
    sum_top    = 10'(win[0]) + (10'(win[3]) << 1) + 10'(ls_top);
    gx_next    = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    gy_next    = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
    meta_next.column = COL_W'(col_count - CW'(1));
    meta_next.row    = row_count - ROW_W'(1);
    meta_next.last   = frame_end;
  end

  // Each stage loads when it is empty or its content moves on.
  always_comb begin
    sq_take[SQRT_STEPS] = !sq_vld[SQRT_STEPS] || out_ready;
    for (int k = SQRT_STEPS - 1; k >= 0; k--) begin
      sq_take[k] = !sq_vld[k] || sq_take[k+1];
    end
    g_take = !g_vld || sq_take[0];
  end

  assign in_ready = g_take;

  // Gradient stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (g_take) begin
      g_vld <= accept && produced;
    end
  end

  always_ff @(posedge clk) begin
    if (g_take) begin
      gx     <= gx_next;
      gy     <= gy_next;
      g_meta <= meta_next;
    end
  end

  // Squares and their sum; anything from 65536 up saturates the magnitude.
  assign gx_sq  = gx * gx;
  assign gy_sq  = gy * gy;
  assign sum_sq = $unsigned(gx_sq) + $unsigned(gy_sq);

  // One result bit per stage: try the bit and keep it if its square fits.
  always_comb begin
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      cand_r[k]  = sq_r[k-1] | (MAG_W'(1) << (SQRT_STEPS - k));
      cand_sq[k] = 17'(sq_rsq[k-1]) + (17'(sq_r[k-1]) << (SQRT_STEPS + 1 - k))
                   + (17'(1) << (2 * (SQRT_STEPS - k)));
      cand_ok[k] = cand_sq[k] <= 17'(sq_v[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        sq_vld[k] <= 1'b0;
      end
    end else begin
      if (sq_take[0]) begin
        sq_vld[0] <= g_vld;
      end
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        if (sq_take[k]) begin
          sq_vld[k] <= sq_vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_take[0]) begin
      sq_v[0]    <= sum_sq[15:0];
      sq_sat[0]  <= |sum_sq[21:16];
      sq_r[0]    <= '0;
      sq_rsq[0]  <= '0;
      sq_meta[0] <= g_meta;
    end
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      if (sq_take[k]) begin
        sq_v[k]    <= sq_v[k-1];
        sq_sat[k]  <= sq_sat[k-1];
        sq_meta[k] <= sq_meta[k-1];
        if (cand_ok[k]) begin
          sq_r[k]   <= cand_r[k];
          sq_rsq[k] <= cand_sq[k][15:0];
        end else begin
          sq_r[k]   <= sq_r[k-1];
          sq_rsq[k] <= sq_rsq[k-1];
        end
      end
    end
  end

  // Result register is the last root stage.
  assign out_valid  = sq_vld[SQRT_STEPS];
  assign magnitude  = sq_sat[SQRT_STEPS] ? MAG_LIMIT : sq_r[SQRT_STEPS];
  assign out_column = sq_meta[SQRT_STEPS].column;
  assign out_row    = sq_meta[SQRT_STEPS].row;
  assign frame_last = sq_meta[SQRT_STEPS].last;

  // A consumer that is ready frees every stage, so the input must be ready.
  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("pixel input stalled while the output was ready");

  // An interior pixel transfer always reaches the gradient stage.
  a_interior_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && produced) |=> g_vld)
    else $error("interior pixel lost before the gradient stage");

  // A blocked gradient stage keeps its result.
  a_grad_hold: assert property (@(posedge clk) disable iff (rst)
    (g_vld && !sq_take[0]) |=> (g_vld && $stable(gx) && $stable(gy)))
    else $error("gradient stage changed while blocked");

  // The column count never leaves the line store.
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    CW1'(col_count) < CW1'(MAX_WIDTH))
    else $error("column count beyond the line store depth");

  // The last pixel of a frame returns the position to the origin.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> (col_count == '0 && row_count == '0))
    else $error("position not cleared at frame end");

endmodule
